// ===== rtl/value_noise_turbulence_unit_defines.svh =====
// Assertion macros shared by the turbulence unit.
`ifndef VALUE_NOISE_TURBULENCE_UNIT_DEFINES_SVH
`define VALUE_NOISE_TURBULENCE_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define VNT_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("turbulence unit check failed");

// Next-cycle implication, checked outside reset.
`define VNT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("turbulence unit check failed");

`endif

// ===== rtl/vnt_pkg.sv =====
`default_nettype none
package vnt_pkg;
   localparam int COORD_W = 16;
   localparam int NOISE_W = 15;
   localparam int OUT_W   = 8;
   localparam int TAB_AW  = 16;
   localparam int KW      = 4;
   localparam int SHIFT_W = 3;
   localparam logic [SHIFT_W-1:0] SHIFT_RESET = 3'd5;

   typedef enum logic {
      OP_LOAD   = 1'b0,
      OP_SAMPLE = 1'b1
   } opcode_type;
endpackage
`default_nettype wire

// ===== rtl/value_noise_turbulence_unit.sv =====
`default_nettype none
`include "value_noise_turbulence_unit_defines.svh"
// Value noise turbulence unit.
// A request is taken when start is high and busy is low. A load request
// (opcode zero) writes one noise entry into the table in that cycle and
// leaves busy low, so loads can follow back to back. A sample request
// raises busy and sums the octaves of the current starting shift.
// The cell of each octave comes from a running remainder that is refined
// one coordinate bit per cycle, so a sample first steps through bits 15
// down to the starting shift S, then reads the eight neighbors from the
// table, one per cycle through the single read port, and takes one step
// and eight reads for each finer octave. A four-stage weight, multiply
// and accumulate pipeline then drains before busy falls. The result is
// shown on rsp_turbulence for exactly one cycle with rsp_strobe high,
// in the cycle busy falls; the receiver cannot stall. A new sample can
// be taken from that cycle on, once busy is low.
// Reset clears the control state and sets the starting shift to five.
// The table is not cleared: every entry must be loaded before sampling.
// The csr port writes the starting shift; write it only while idle.
module value_noise_turbulence_unit
   import vnt_pkg::*;
#(
   parameter int GRID_X = 64,
   parameter int GRID_Y = 64,
   parameter int GRID_Z = 16,
   parameter int MAX_OCTAVE_SHIFT = 7
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire logic                 req_opcode,
   input  wire logic [COORD_W-1:0]   req_x_coord,
   input  wire logic [COORD_W-1:0]   req_y_coord,
   input  wire logic [COORD_W-1:0]   req_z_coord,
   input  wire logic [TAB_AW-1:0]    req_table_index,
   input  wire logic [NOISE_W-1:0]   req_noise_value,
   output logic                      rsp_strobe,
   output logic [OUT_W-1:0]          rsp_turbulence,
   input  wire logic                 csr_wr_en,
   input  wire logic [SHIFT_W-1:0]   csr_wr_data
);
   localparam int CXW  = (GRID_X > 1) ? $clog2(GRID_X) : 1;
   localparam int CYW  = (GRID_Y > 1) ? $clog2(GRID_Y) : 1;
   localparam int CZW  = (GRID_Z > 1) ? $clog2(GRID_Z) : 1;
   localparam int WW   = MAX_OCTAVE_SHIFT + 1;
   localparam int ACCW = 3 * MAX_OCTAVE_SHIFT + 17;
   localparam int SHP  = (MAX_OCTAVE_SHIFT > 0) ? $clog2(2 * MAX_OCTAVE_SHIFT + 1) : 1;
   localparam int SHOW = $clog2(3 * MAX_OCTAVE_SHIFT + 9);
   localparam int DEPTH = 2 ** TAB_AW;

   typedef enum logic [1:0] {S_IDLE, S_STEP, S_READ, S_DRAIN} state_type;

   // Noise table, one write and one registered read per cycle.
   logic [NOISE_W-1:0] mem [DEPTH];

   state_type              state_ff;
   logic [KW-1:0]          k_ff;
   logic [2:0]             n_ff;
   logic [1:0]             drain_ff;
   logic [KW-1:0]          s_ff;
   logic [SHIFT_W-1:0]     csr_shift_ff;
   logic [COORD_W-1:0]     x_ff, y_ff, z_ff;
   logic [CXW-1:0]         rx_ff, rx_in;
   logic [CYW-1:0]         ry_ff, ry_in;
   logic [CZW-1:0]         rz_ff, rz_in;

   // Pipeline: issue, weight product, noise product, accumulate.
   logic                   v1_ff, v2_ff, v3_ff;
   logic [2*WW-1:0]        wxy_ff;
   logic [WW-1:0]          wz_ff;
   logic [SHP-1:0]         sh1_ff, sh2_ff, sh3_ff;
   logic [NOISE_W-1:0]     rd_ff;
   logic [3*WW-1:0]        w3_ff;
   logic [NOISE_W-1:0]     rd2_ff;
   logic [3*WW+NOISE_W-1:0] prod_ff;
   logic [ACCW-1:0]        acc_ff;
   logic                   rsp_strobe_ff;
   logic [OUT_W-1:0]       rsp_turbulence_ff;

   logic                   accept;
   logic [KW-1:0]          s_clamp;
   logic [WW-1:0]          size_w, fmask, fx, fy, fz, wx, wy, wz;
   logic [CXW-1:0]         xm, cx;
   logic [CYW-1:0]         ym, cy;
   logic [CZW-1:0]         zm, cz;
   logic [31:0]            flat;
   logic [SHP-1:0]         sh_issue;
   logic [SHOW-1:0]        out_shift;
   logic [CXW:0]           tx;
   logic [CYW:0]           ty;
   logic [CZW:0]           tz;

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;
   assign s_clamp = (KW'(csr_shift_ff) > KW'(MAX_OCTAVE_SHIFT)) ?
                    KW'(MAX_OCTAVE_SHIFT) : KW'(csr_shift_ff);

   // Remainder step: cell of the next finer octave modulo the grid.
   always_comb begin
      tx = {rx_ff, x_ff[k_ff]};
      ty = {ry_ff, y_ff[k_ff]};
      tz = {rz_ff, z_ff[k_ff]};
      rx_in = (tx >= (CXW+1)'(GRID_X)) ? CXW'(tx - (CXW+1)'(GRID_X)) : CXW'(tx);
      ry_in = (ty >= (CYW+1)'(GRID_Y)) ? CYW'(ty - (CYW+1)'(GRID_Y)) : CYW'(ty);
      rz_in = (tz >= (CZW+1)'(GRID_Z)) ? CZW'(tz - (CZW+1)'(GRID_Z)) : CZW'(tz);
   end

   // Neighbor address and weights for the read issued this cycle.
   always_comb begin
      size_w = WW'(1) << k_ff;
      fmask  = size_w - WW'(1);
      fx = WW'(x_ff) & fmask;
      fy = WW'(y_ff) & fmask;
      fz = WW'(z_ff) & fmask;
      wx = n_ff[2] ? size_w - fx : fx;
      wy = n_ff[1] ? size_w - fy : fy;
      wz = n_ff[0] ? size_w - fz : fz;
      xm = (rx_ff == '0) ? CXW'(GRID_X - 1) : rx_ff - CXW'(1);
      ym = (ry_ff == '0) ? CYW'(GRID_Y - 1) : ry_ff - CYW'(1);
      zm = (rz_ff == '0) ? CZW'(GRID_Z - 1) : rz_ff - CZW'(1);
      cx = n_ff[2] ? xm : rx_ff;
      cy = n_ff[1] ? ym : ry_ff;
      cz = n_ff[0] ? zm : rz_ff;
      flat = (32'(cx) * 32'(GRID_Y) + 32'(cy)) * 32'(GRID_Z) + 32'(cz);
      sh_issue = SHP'({(s_ff - k_ff), 1'b0});
      out_shift = SHOW'(3) * SHOW'(s_ff) + SHOW'(8);
   end

   always_ff @(posedge clock) begin
      if (accept && (opcode_type'(req_opcode) == OP_LOAD)) begin
         mem[req_table_index] <= req_noise_value;
      end
      rd_ff <= mem[flat[TAB_AW-1:0]];
   end

   always_ff @(posedge clock) begin
      wxy_ff  <= (2*WW)'(wx) * (2*WW)'(wy);
      wz_ff   <= wz;
      sh1_ff  <= sh_issue;
      w3_ff   <= (3*WW)'(wxy_ff) * (3*WW)'(wz_ff);
      rd2_ff  <= rd_ff;
      sh2_ff  <= sh1_ff;
      prod_ff <= (3*WW+NOISE_W)'(w3_ff) * (3*WW+NOISE_W)'(rd2_ff);
      sh3_ff  <= sh2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         csr_shift_ff  <= SHIFT_RESET;
         v1_ff         <= 1'b0;
         v2_ff         <= 1'b0;
         v3_ff         <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         k_ff          <= '0;
         n_ff          <= '0;
         drain_ff      <= '0;
      end else begin
         if (csr_wr_en) begin
            csr_shift_ff <= csr_wr_data;
         end
         v1_ff <= (state_ff == S_READ);
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         if (v3_ff) begin
            acc_ff <= acc_ff + (ACCW'(prod_ff) << sh3_ff);
         end
         rsp_turbulence_ff <= OUT_W'(acc_ff >> out_shift);
         rsp_strobe_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (accept && (opcode_type'(req_opcode) == OP_SAMPLE)) begin
                  x_ff     <= req_x_coord;
                  y_ff     <= req_y_coord;
                  z_ff     <= req_z_coord;
                  s_ff     <= s_clamp;
                  k_ff     <= KW'(COORD_W - 1);
                  rx_ff    <= '0;
                  ry_ff    <= '0;
                  rz_ff    <= '0;
                  acc_ff   <= '0;
                  state_ff <= S_STEP;
               end
            end
            S_STEP: begin
               rx_ff <= rx_in;
               ry_ff <= ry_in;
               rz_ff <= rz_in;
               if (k_ff <= s_ff) begin
                  n_ff     <= '0;
                  state_ff <= S_READ;
               end else begin
                  k_ff <= k_ff - KW'(1);
               end
            end
            S_READ: begin
               n_ff <= n_ff + 3'd1;
               if (n_ff == 3'd7) begin
                  if (k_ff == '0) begin
                     drain_ff <= '0;
                     state_ff <= S_DRAIN;
                  end else begin
                     k_ff     <= k_ff - KW'(1);
                     state_ff <= S_STEP;
                  end
               end
            end
            S_DRAIN: begin
               drain_ff <= drain_ff + 2'd1;
               if (drain_ff == 2'd3) begin
                  rsp_strobe_ff <= 1'b1;
                  state_ff      <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_turbulence = rsp_turbulence_ff;

   `VNT_ASSERT_NOW(a_strobe_idle, clock, reset, rsp_strobe, state_ff == S_IDLE)
   `VNT_ASSERT_NEXT(a_sample_busy, clock, reset,
      accept && (opcode_type'(req_opcode) == OP_SAMPLE), busy)
   `VNT_ASSERT_NOW(a_strobe_after_drain, clock, reset, rsp_strobe,
      $past(state_ff) == S_DRAIN)
   `VNT_ASSERT_NOW(a_read_in_range, clock, reset, state_ff == S_READ, k_ff <= s_ff)
endmodule
`default_nettype wire
